// File: rtl/acir_pkg.sv
// Shared types, constants and helper functions for the infrared air-conditioner frame decoder.
// No dependencies; every module of the block imports this package.
package acir_pkg;

	localparam logic [4:0] HDR_LEN     = 5'd8;
	localparam logic [4:0] HDR_LAST    = 5'd7;
	localparam logic [4:0] PFX_LEN     = 5'd5;
	localparam logic [4:0] POS_MAX     = 5'd31;

	// Byte positions within the payload frame.
	localparam logic [4:0] POS_MODE    = 5'd5;
	localparam logic [4:0] POS_TEMP    = 5'd6;
	localparam logic [4:0] POS_FAN     = 5'd8;
	localparam logic [4:0] POS_HSWING  = 5'd9;
	localparam logic [4:0] POS_QUIET   = 5'd13;
	localparam logic [4:0] POS_FOLLOW  = 5'd16;
	localparam logic [4:0] POS_CHECK   = 5'd18;

	localparam logic [7:0]  TEMP_OFFSET = 8'd20;
	localparam logic [11:0] TEMP_SCALE  = 12'd9;
	localparam logic [11:0] TEMP_ROUND  = 12'd5;
	localparam logic [7:0]  TEMP_BASE   = 8'd50;
	// 3277 / 2^15 approximates one tenth closely enough for dividends below 4096.
	localparam logic [11:0] RECIP10     = 12'd3277;

	typedef logic [4:0] pos_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_HDR   = 2'd1,
		STATUS_BAD_FRAME = 2'd2,
		STATUS_BAD_SUM   = 2'd3
	} status_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] mode;
		logic       power_on;
		logic [7:0] temp_f;
		logic [3:0] fan;
		logic       swing_vertical;
		logic       swing_horizontal;
		logic       quiet;
		logic       follow_me;
	} result_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] val;
		unique case (idx)
			3'd0: val = 8'h11;
			3'd1: val = 8'hda;
			3'd2: val = 8'h27;
			3'd3: val = 8'hf0;
			3'd4: val = 8'h00;
			3'd5: val = 8'h00;
			3'd6: val = 8'h00;
			3'd7: val = 8'h02;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	function automatic logic [7:0] pfx_byte(input logic [2:0] idx);
		logic [7:0] val;
		unique case (idx)
			3'd0: val = 8'h11;
			3'd1: val = 8'hda;
			3'd2: val = 8'h27;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

	// Celsius-like raw code to Fahrenheit: (raw - 20) * 0.9 rounded half away from zero,
	// plus 50, wrapping in eight bits.
	function automatic logic [7:0] temp_from_raw(input logic [7:0] raw);
		logic        neg;
		logic [7:0]  diff;
		logic [11:0] mag;
		logic [23:0] prod;
		logic [7:0]  q;
		neg  = raw < TEMP_OFFSET;
		diff = neg ? (TEMP_OFFSET - raw) : (raw - TEMP_OFFSET);
		mag  = 12'(diff) * TEMP_SCALE + TEMP_ROUND;
		prod = 24'(mag) * 24'(RECIP10);
		q    = prod[22:15];
		return neg ? (TEMP_BASE - q) : (TEMP_BASE + q);
	endfunction

endpackage

// File: rtl/acir_if.sv
// Valid/ready channel interfaces for the byte stream and the decoded results.
// No dependencies.
interface acir_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface acir_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [3:0] mode;
	logic       power_on;
	logic [7:0] temp_f;
	logic [3:0] fan;
	logic       swing_vertical;
	logic       swing_horizontal;
	logic       quiet;
	logic       follow_me;

	modport source (output valid, output status, output mode, output power_on, output temp_f,
		output fan, output swing_vertical, output swing_horizontal, output quiet,
		output follow_me, input ready);
	modport sink   (input valid, input status, input mode, input power_on, input temp_f,
		input fan, input swing_vertical, input swing_horizontal, input quiet,
		input follow_me, output ready);
endinterface

// File: rtl/ac_ir_frame_decoder.sv
// Two-frame infrared air-conditioner message decoder, top level.
// Throughput: one byte per cycle while the output stage has room; the per-byte check and
// capture logic is combinational. The result is registered into the output stage on the transfer
// of the payload's last byte; its two entries keep bytes flowing while one result waits.
// Reset (arst_n low, asynchronous): expects a header, no result pending; no clearing pass.
// Depends on acir_pkg, acir_if, acir_frame_track and acir_out_skid.
module ac_ir_frame_decoder
	import acir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	acir_in_if.sink    byte_stream,
	acir_out_if.source result
);

	logic    take;
	logic    can_take;
	logic    res_valid;
	result_t res;

	assign byte_stream.ready = can_take;
	assign take = byte_stream.valid && can_take;

	acir_frame_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (byte_stream.data_byte),
		.frame_end (byte_stream.frame_end),
		.res_valid (res_valid),
		.res       (res)
	);

	acir_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_take  (can_take),
		.result    (result)
	);

endmodule

// File: rtl/acir_frame_track.sv
// Per-byte frame tracking: header and prefix checks, checksum, field capture and status.
// Depends on acir_pkg.
module acir_frame_track
	import acir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       frame_end,
	output logic       res_valid,
	output result_t    res
);

	logic       in_payload_q;
	pos_t       pos_q;
	logic       header_good_q;
	logic       prefix_good_q;
	logic [7:0] sum_q;
	logic       check_good_q;

	logic [3:0] mode_q;
	logic       power_q;
	logic [7:0] temp_q;
	logic [3:0] fan_q;
	logic       vswing_q;
	logic       hswing_q;
	logic       quiet_q;
	logic       follow_q;

	pos_t       pos_inc;
	logic       hdr_ok_n;
	logic       pfx_ok_n;
	logic       check_n;
	status_t    status_n;

	always_comb begin
		pos_inc = (pos_q < POS_MAX) ? pos_q + 5'd1 : pos_q;

		hdr_ok_n = header_good_q;
		if (pos_q >= HDR_LEN || data_byte != hdr_byte(pos_q[2:0])) begin
			hdr_ok_n = 1'b0;
		end

		pfx_ok_n = prefix_good_q;
		if (pos_q < PFX_LEN && data_byte != pfx_byte(pos_q[2:0])) begin
			pfx_ok_n = 1'b0;
		end

		check_n = (pos_q == POS_CHECK) ? (data_byte == sum_q) : check_good_q;

		priority if (!header_good_q) begin
			status_n = STATUS_BAD_HDR;
		end else if (pos_q != POS_CHECK || !pfx_ok_n) begin
			status_n = STATUS_BAD_FRAME;
		end else if (!check_n) begin
			status_n = STATUS_BAD_SUM;
		end else begin
			status_n = STATUS_OK;
		end
	end

	assign res_valid = take && in_payload_q && frame_end;

	always_comb begin
		res = '0;
		res.status = status_n;
		if (status_n == STATUS_OK) begin
			res.mode             = mode_q;
			res.power_on         = power_q;
			res.temp_f           = temp_q;
			res.fan              = fan_q;
			res.swing_vertical   = vswing_q;
			res.swing_horizontal = hswing_q;
			res.quiet            = quiet_q;
			res.follow_me        = follow_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q  <= 1'b0;
			pos_q         <= '0;
			header_good_q <= 1'b1;
			prefix_good_q <= 1'b1;
			sum_q         <= '0;
			check_good_q  <= 1'b0;
		end else if (take) begin
			if (!in_payload_q) begin
				if (frame_end) begin
					// The header must end exactly on its eighth byte.
					header_good_q <= hdr_ok_n && (pos_q == HDR_LAST);
					in_payload_q  <= 1'b1;
					pos_q         <= '0;
					prefix_good_q <= 1'b1;
					sum_q         <= '0;
					check_good_q  <= 1'b0;
				end else begin
					header_good_q <= hdr_ok_n;
					pos_q         <= pos_inc;
				end
			end else begin
				prefix_good_q <= pfx_ok_n;
				check_good_q  <= check_n;
				if (pos_q < POS_CHECK) begin
					sum_q <= sum_q + data_byte;
				end
				if (frame_end) begin
					in_payload_q  <= 1'b0;
					pos_q         <= '0;
					header_good_q <= 1'b1;
				end else begin
					pos_q <= pos_inc;
				end
			end
		end
	end

	// Captured fields are only reported for a complete, valid payload, so they need no reset.
	always_ff @(posedge clk) begin
		if (take && in_payload_q) begin
			unique case (pos_q)
				POS_MODE: begin
					mode_q  <= data_byte[7:4];
					power_q <= data_byte[0];
				end
				POS_TEMP: begin
					temp_q <= temp_from_raw(data_byte);
				end
				POS_FAN: begin
					fan_q    <= data_byte[7:4];
					vswing_q <= |data_byte[3:0];
				end
				POS_HSWING: begin
					hswing_q <= |data_byte[3:0];
				end
				POS_QUIET: begin
					quiet_q <= |data_byte[7:4];
				end
				POS_FOLLOW: begin
					follow_q <= |data_byte[3:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/acir_out_skid.sv
// Result output register with a skid stage, so the byte side keeps moving while a result waits.
// Depends on acir_pkg and acir_out_if.
module acir_out_skid
	import acir_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  result_t     push_data,
	output logic        can_take,
	acir_out_if.source  result
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop      = main_valid_q && result.ready;
	assign can_take = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// A push never coincides with a full skid stage, as the input side is held off then.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign result.valid            = main_valid_q;
	assign result.status           = main_q.status;
	assign result.mode             = main_q.mode;
	assign result.power_on         = main_q.power_on;
	assign result.temp_f           = main_q.temp_f;
	assign result.fan              = main_q.fan;
	assign result.swing_vertical   = main_q.swing_vertical;
	assign result.swing_horizontal = main_q.swing_horizontal;
	assign result.quiet            = main_q.quiet;
	assign result.follow_me        = main_q.follow_me;

endmodule
